[rtl/core/app_packet_framer_xor_check_defines.svh]
// Assertion macros shared by the framer RTL.
`ifndef APP_PACKET_FRAMER_XOR_CHECK_DEFINES_SVH
`define APP_PACKET_FRAMER_XOR_CHECK_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define APFX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define APFX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/apfx_pkg.sv]
`default_nettype none
package apfx_pkg;

  localparam int unsigned MAX_SIZE_BYTES = 4;
  // Wide enough for any byte count up to eight.
  localparam int unsigned SZ_CNT_W = 4;

  localparam logic [1:0] MODE_DATA  = 2'd0;
  localparam logic [1:0] MODE_BEGIN = 2'd1;

  localparam logic [7:0] TYPE_DATA  = 8'h01;
  localparam logic [7:0] TYPE_BEGIN = 8'h02;
  localparam logic [7:0] TYPE_END   = 8'h03;
  localparam logic [7:0] TLV_SIZE   = 8'h00;
  localparam logic [7:0] TLV_NAME   = 8'h01;
  localparam logic [7:0] SAT_BYTE   = 8'hFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TYPE,
    ST_SEQ,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_T0_TYPE,
    ST_T0_LEN,
    ST_SIZE,
    ST_T1_TYPE,
    ST_T1_LEN,
    ST_DATA,
    ST_CHECK
  } state_e;

  typedef enum logic [3:0] {
    SEL_TYPE,
    SEL_SEQ,
    SEL_LEN_HI,
    SEL_LEN_LO,
    SEL_ZERO,
    SEL_CNT,
    SEL_SIZE,
    SEL_ONE,
    SEL_NLEN,
    SEL_DATA,
    SEL_CHECK
  } sel_e;

  typedef struct packed {
    logic load;
    logic emit;
    sel_e sel;
    logic size_init;
    logic size_step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_data;
    logic last;
    logic size_done;
  } sts_t;

  // Minimal number of bytes that hold the size, at least one.
  function automatic logic [SZ_CNT_W-1:0] size_need(input logic [31:0] s);
    logic [SZ_CNT_W-1:0] n;
    if (s[31:24] != 8'h00) begin
      n = SZ_CNT_W'(4);
    end else if (s[23:16] != 8'h00) begin
      n = SZ_CNT_W'(3);
    end else if (s[15:8] != 8'h00) begin
      n = SZ_CNT_W'(2);
    end else begin
      n = SZ_CNT_W'(1);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

[rtl/core/apfx_dp.sv]
`default_nettype none
module apfx_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [1:0]         mode_i,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic               last_i,
  input  wire logic [7:0]         sequence_number_i,
  input  wire logic [15:0]        payload_length_i,
  input  wire logic [31:0]        file_size_i,
  input  wire logic [7:0]         name_length_i,
  input  wire apfx_pkg::cmd_t     cmd_i,
  input  wire logic               out_stall_i,
  output apfx_pkg::sts_t          sts_o,
  output logic                    out_valid_o,
  output logic [7:0]              out_byte_o,
  output logic                    out_last_o
);

  logic [1:0]                     mode_q;
  logic [7:0]                     data_q;
  logic                           last_q;
  logic [7:0]                     seq_q;
  logic [15:0]                    plen_q;
  logic [31:0]                    fsize_q;
  logic [7:0]                     nlen_q;
  logic [apfx_pkg::SZ_CNT_W-1:0]  cnt_q;
  logic                           sat_q;
  logic [apfx_pkg::SZ_CNT_W-1:0]  idx_q;
  logic [apfx_pkg::SZ_CNT_W-1:0]  idx_d;
  logic [7:0]                     xor_q;
  logic [7:0]                     xor_d;
  logic                           out_valid_q;
  logic [7:0]                     out_byte_q;
  logic                           out_last_q;
  logic [apfx_pkg::SZ_CNT_W-1:0]  need;
  logic                           sat;
  logic [7:0]                     byte_sel;
  logic [7:0]                     size_byte;

  assign need = apfx_pkg::size_need(file_size_i);
  assign sat  = need > apfx_pkg::SZ_CNT_W'(apfx_pkg::MAX_SIZE_BYTES);

  // Input capture; the size byte count is settled at capture time.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      data_q  <= data_byte_i;
      last_q  <= last_i;
      seq_q   <= sequence_number_i;
      plen_q  <= payload_length_i;
      fsize_q <= file_size_i;
      nlen_q  <= name_length_i;
      sat_q   <= sat;
      cnt_q   <= sat ? apfx_pkg::SZ_CNT_W'(apfx_pkg::MAX_SIZE_BYTES) : need;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.size_init) begin
      idx_d = cnt_q - apfx_pkg::SZ_CNT_W'(1);
    end else if (cmd_i.size_step) begin
      idx_d = idx_q - apfx_pkg::SZ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  // Size bytes go out most significant first; only the low two index bits pick the byte.
  assign size_byte = sat_q ? apfx_pkg::SAT_BYTE : fsize_q[{idx_q[1:0], 3'b000} +: 8];

  always_comb begin
    case (cmd_i.sel)
      apfx_pkg::SEL_TYPE: begin
        if (mode_q == apfx_pkg::MODE_DATA) begin
          byte_sel = apfx_pkg::TYPE_DATA;
        end else if (mode_q == apfx_pkg::MODE_BEGIN) begin
          byte_sel = apfx_pkg::TYPE_BEGIN;
        end else begin
          byte_sel = apfx_pkg::TYPE_END;
        end
      end
      apfx_pkg::SEL_SEQ:    byte_sel = seq_q;
      apfx_pkg::SEL_LEN_HI: byte_sel = plen_q[15:8];
      apfx_pkg::SEL_LEN_LO: byte_sel = plen_q[7:0];
      apfx_pkg::SEL_ZERO:   byte_sel = apfx_pkg::TLV_SIZE;
      apfx_pkg::SEL_CNT:    byte_sel = 8'(cnt_q);
      apfx_pkg::SEL_SIZE:   byte_sel = size_byte;
      apfx_pkg::SEL_ONE:    byte_sel = apfx_pkg::TLV_NAME;
      apfx_pkg::SEL_NLEN:   byte_sel = nlen_q;
      apfx_pkg::SEL_DATA:   byte_sel = data_q;
      apfx_pkg::SEL_CHECK:  byte_sel = xor_q;
      default:              byte_sel = data_q;
    endcase
  end

  // The type byte restarts the running XOR and the check byte clears it.
  always_comb begin
    xor_d = xor_q;
    if (cmd_i.emit) begin
      if (cmd_i.sel == apfx_pkg::SEL_TYPE) begin
        xor_d = byte_sel;
      end else if (cmd_i.sel == apfx_pkg::SEL_CHECK) begin
        xor_d = 8'h00;
      end else begin
        xor_d = xor_q ^ byte_sel;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q       <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      xor_q <= xor_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_byte_q <= byte_sel;
      out_last_q <= (cmd_i.sel == apfx_pkg::SEL_CHECK);
    end
  end

  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.is_data   = (mode_q == apfx_pkg::MODE_DATA);
  assign sts_o.last      = last_q;
  assign sts_o.size_done = (idx_q == '0);

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

[rtl/core/apfx_ctrl.sv]
`default_nettype none
module apfx_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            first_i,
  input  wire apfx_pkg::sts_t  sts_i,
  output logic                 in_stall_o,
  output apfx_pkg::cmd_t       cmd_o
);

  apfx_pkg::state_e state_q;
  apfx_pkg::state_e state_d;
  apfx_pkg::state_e entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= apfx_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A new request takes the header path only when it opens a packet.
  assign entry = first_i ? apfx_pkg::ST_TYPE : apfx_pkg::ST_DATA;

  // Outputs.
  always_comb begin
    cmd_o.emit      = (state_q != apfx_pkg::ST_IDLE) && sts_i.out_free;
    cmd_o.size_init = 1'b0;
    cmd_o.size_step = 1'b0;
    in_stall_o      = 1'b1;
    case (state_q)
      apfx_pkg::ST_IDLE: begin
        cmd_o.sel  = apfx_pkg::SEL_DATA;
        in_stall_o = 1'b0;
      end
      apfx_pkg::ST_TYPE:    cmd_o.sel = apfx_pkg::SEL_TYPE;
      apfx_pkg::ST_SEQ:     cmd_o.sel = apfx_pkg::SEL_SEQ;
      apfx_pkg::ST_LEN_HI:  cmd_o.sel = apfx_pkg::SEL_LEN_HI;
      apfx_pkg::ST_LEN_LO:  cmd_o.sel = apfx_pkg::SEL_LEN_LO;
      apfx_pkg::ST_T0_TYPE: cmd_o.sel = apfx_pkg::SEL_ZERO;
      apfx_pkg::ST_T0_LEN: begin
        cmd_o.sel       = apfx_pkg::SEL_CNT;
        cmd_o.size_init = cmd_o.emit;
      end
      apfx_pkg::ST_SIZE: begin
        cmd_o.sel       = apfx_pkg::SEL_SIZE;
        cmd_o.size_step = cmd_o.emit;
      end
      apfx_pkg::ST_T1_TYPE: cmd_o.sel = apfx_pkg::SEL_ONE;
      apfx_pkg::ST_T1_LEN:  cmd_o.sel = apfx_pkg::SEL_NLEN;
      apfx_pkg::ST_DATA: begin
        cmd_o.sel  = apfx_pkg::SEL_DATA;
        in_stall_o = !(sts_i.out_free && !sts_i.last);
      end
      apfx_pkg::ST_CHECK:   cmd_o.sel = apfx_pkg::SEL_CHECK;
      default:              cmd_o.sel = apfx_pkg::SEL_DATA;
    endcase
    cmd_o.load = in_valid_i && !in_stall_o;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      apfx_pkg::ST_IDLE: begin
        if (cmd_o.load) state_d = entry;
      end
      apfx_pkg::ST_TYPE: begin
        if (cmd_o.emit) begin
          state_d = sts_i.is_data ? apfx_pkg::ST_SEQ : apfx_pkg::ST_T0_TYPE;
        end
      end
      apfx_pkg::ST_SEQ:     if (cmd_o.emit) state_d = apfx_pkg::ST_LEN_HI;
      apfx_pkg::ST_LEN_HI:  if (cmd_o.emit) state_d = apfx_pkg::ST_LEN_LO;
      apfx_pkg::ST_LEN_LO:  if (cmd_o.emit) state_d = apfx_pkg::ST_DATA;
      apfx_pkg::ST_T0_TYPE: if (cmd_o.emit) state_d = apfx_pkg::ST_T0_LEN;
      apfx_pkg::ST_T0_LEN:  if (cmd_o.emit) state_d = apfx_pkg::ST_SIZE;
      apfx_pkg::ST_SIZE: begin
        if (cmd_o.emit && sts_i.size_done) state_d = apfx_pkg::ST_T1_TYPE;
      end
      apfx_pkg::ST_T1_TYPE: if (cmd_o.emit) state_d = apfx_pkg::ST_T1_LEN;
      apfx_pkg::ST_T1_LEN:  if (cmd_o.emit) state_d = apfx_pkg::ST_DATA;
      apfx_pkg::ST_DATA: begin
        if (cmd_o.emit) begin
          if (sts_i.last) begin
            state_d = apfx_pkg::ST_CHECK;
          end else if (cmd_o.load) begin
            state_d = entry;
          end else begin
            state_d = apfx_pkg::ST_IDLE;
          end
        end
      end
      apfx_pkg::ST_CHECK:   if (cmd_o.emit) state_d = apfx_pkg::ST_IDLE;
      default:              state_d = apfx_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/app_packet_framer_xor_check.sv]
// The first framed byte of a request passes the sequencer state register and then the output
// register. A data byte that neither opens nor closes a packet is taken while the one before
// it leaves the single output register, unless the output stalls; a data header adds four bytes,
// a control header five plus the size byte count (1 to 4), and the check byte is followed by idle.
// Reset (rst_ni low, asynchronous) empties the output register, returns the sequencer
// to idle and clears the running XOR; no clearing pass is needed.
`default_nettype none
`include "app_packet_framer_xor_check_defines.svh"
module app_packet_framer_xor_check (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request channel: one payload or file name byte per request.
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        first_i,
  input  wire logic        last_i,
  input  wire logic [7:0]  sequence_number_i,
  input  wire logic [15:0] payload_length_i,
  input  wire logic [31:0] file_size_i,
  input  wire logic [7:0]  name_length_i,
  // Framed byte stream.
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o
);

  // The controller walks through the header, data and check byte of a request and
  // advances one byte select per cycle while the output register is free; the datapath
  // holds the captured request, the size byte index, the running XOR and the output register.
  apfx_pkg::cmd_t cmd;
  apfx_pkg::sts_t sts;

  apfx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .first_i    (first_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  apfx_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .mode_i            (mode_i),
    .data_byte_i       (data_byte_i),
    .last_i            (last_i),
    .sequence_number_i (sequence_number_i),
    .payload_length_i  (payload_length_i),
    .file_size_i       (file_size_i),
    .name_length_i     (name_length_i),
    .cmd_i             (cmd),
    .out_stall_i       (out_stall_i),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_byte_o        (out_byte_o),
    .out_last_o        (out_last_o)
  );

  // A byte is only pushed into the output register when it is empty or being drained.
  `APFX_ASSERT_NOW(a_emit_free, cmd.emit, !(out_valid_o && out_stall_i), "emit into full output")
  // A new request is only taken while idle or while its predecessor's data byte leaves.
  `APFX_ASSERT_NOW(a_load_slot, cmd.load && cmd.emit, cmd.sel == apfx_pkg::SEL_DATA,
                   "request taken during header or check")
  // The check byte shows up on the next cycle marked as the packet end.
  `APFX_ASSERT_NEXT(a_check_last, cmd.emit && cmd.sel == apfx_pkg::SEL_CHECK,
                    out_valid_o && out_last_o, "check byte not flagged as last")

endmodule
`default_nettype wire
